// ===== rtl/dedup_packet_fifo_with_range_count_top_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_TOP_MACROS_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_TOP_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define DPF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define DPF_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dpf_pkg.sv =====
package dpf_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int SCAN_LANES = 8;
   localparam logic [6:0] MEM_LIMIT_RESET = 7'd64;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_FORWARD = 2'd1;
   localparam logic [1:0] OP_COUNT   = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } dpf_req_type;

   typedef struct packed {
      logic        accepted;
      logic        queue_empty;
      logic [15:0] out_source;
      logic [15:0] out_destination;
      logic [31:0] out_timestamp;
      logic [6:0]  match_count;
   } dpf_rsp_type;

   typedef struct packed {
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
   } dpf_entry_type;

   typedef struct packed {
      logic          shift;
      logic          count_mode;
      dpf_entry_type key;
      logic [31:0]   start_time;
      logic [31:0]   end_time;
   } dpf_cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_FINISH
   } dpf_state_type;

endpackage

// ===== rtl/dpf_cell.sv =====
module dpf_cell import dpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dpf_cell_ctrl_type ctrl,
   input  logic              load_here,
   input  dpf_entry_type     next_entry,
   input  logic              next_valid,
   output dpf_entry_type     entry,
   output logic              valid,
   output logic              match
);

   dpf_entry_type entry_ff, entry_in;
   logic          valid_ff, valid_in;
   logic          hit_add, hit_count;

   // a load wins over the shift: an evicting add lands in the freed slot
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (load_here) begin
         entry_in = ctrl.key;
         valid_in = 1'b1;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign hit_add   = (entry_ff == ctrl.key);
   assign hit_count = (entry_ff.destination == ctrl.key.destination) &&
                      (entry_ff.timestamp >= ctrl.start_time) &&
                      (entry_ff.timestamp <= ctrl.end_time);

   assign match = valid_ff & (ctrl.count_mode ? hit_count : hit_add);
   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/dedup_packet_fifo_with_range_count_top.sv =====
// Each request steps through the states: forward and unused opcode IDLE, FINISH; add IDLE,
// EVAL, FINISH; count IDLE, EVAL, SCAN, FINISH (the scan adds up the cell hits eight at a time
// and stops when none remain). Requests are taken only in IDLE, one at a time;
// a waiting result does not block the next request from being taken.
// Synchronous active-high reset empties the queue, sets memory_limit to 64
// and clears the result valid; stored packet data is not cleared.
module dedup_packet_fifo_with_range_count_top import dpf_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dpf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dpf_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIM_W = (OCC_W > 7) ? OCC_W : 7;
   localparam int CHUNK = (QUEUE_DEPTH < SCAN_LANES) ? QUEUE_DEPTH : SCAN_LANES;
   localparam int PC_W  = $clog2(CHUNK + 1);

   dpf_state_type            state_ff, state_in;
   dpf_req_type              key_ff, key_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [6:0]               limit_ff, limit_in;
   logic [QUEUE_DEPTH-1:0]   scan_ff, scan_in;
   logic [6:0]               acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dpf_rsp_type              rsp_data_ff, rsp_data_in;

   dpf_cell_ctrl_type        cell_ctrl;
   dpf_entry_type            cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   cell_valid;
   logic [QUEUE_DEPTH-1:0]   cell_match;
   logic [QUEUE_DEPTH-1:0]   load_vec;

   logic                     req_take;
   logic                     finish_go;
   logic                     is_add, is_fwd, is_count;
   logic                     dup, do_store, evict, occ_zero, wr_en;
   logic [LIM_W-1:0]         eff_lim, occ_ext, wr_pos;
   logic [IDX_W-1:0]         wr_idx;
   logic [QUEUE_DEPTH-1:0]   scan_shift;
   logic [PC_W-1:0]          popcnt;
   logic [7:0]               acc_sum;
   dpf_rsp_type              rsp_next;

   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign is_add   = (key_ff.opcode == OP_ADD);
   assign is_fwd   = (key_ff.opcode == OP_FORWARD);
   assign is_count = (key_ff.opcode == OP_COUNT);

   // zero limit acts as one; limits above the depth saturate
   always_comb begin
      if (limit_ff == 7'd0) begin
         eff_lim = LIM_W'(1);
      end else if (LIM_W'(limit_ff) > LIM_W'(QUEUE_DEPTH)) begin
         eff_lim = LIM_W'(QUEUE_DEPTH);
      end else begin
         eff_lim = LIM_W'(limit_ff);
      end
   end

   assign occ_ext  = LIM_W'(occ_ff);
   assign occ_zero = (occ_ff == '0);
   assign evict    = (occ_ext >= eff_lim);
   assign dup      = |scan_ff;
   assign do_store = is_add && !dup;
   assign wr_pos   = evict ? (occ_ext - LIM_W'(1)) : occ_ext;
   assign wr_idx   = wr_pos[IDX_W-1:0];
   assign wr_en    = finish_go && do_store;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.opcode == OP_ADD || req_data.opcode == OP_COUNT) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EVAL: begin
            state_in = is_count ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (scan_shift == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_EVAL:   req_stall = 1'b1;
         ST_SCAN:   req_stall = 1'b1;
         ST_FINISH: finish_go = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   // popcount of the lowest chunk of pending hits
   always_comb begin
      popcnt = '0;
      for (int i = 0; i < CHUNK; i++) begin
         popcnt = popcnt + PC_W'(scan_ff[i]);
      end
   end

   assign scan_shift = scan_ff >> CHUNK;
   assign acc_sum    = 8'(acc_ff) + 8'(popcnt);

   always_comb begin
      scan_in = scan_ff;
      acc_in  = acc_ff;
      if (state_ff == ST_EVAL) begin
         scan_in = cell_match;
         acc_in  = 7'd0;
      end else if (state_ff == ST_SCAN) begin
         scan_in = scan_shift;
         acc_in  = (acc_sum > 8'd127) ? 7'd127 : acc_sum[6:0];
      end
   end

   assign key_in   = req_take ? req_data : key_ff;
   assign limit_in = csr_valid ? csr_data : limit_ff;

   always_comb begin
      occ_in = occ_ff;
      if (finish_go) begin
         if (is_fwd && !occ_zero) begin
            occ_in = occ_ff - OCC_W'(1);
         end else if (do_store && !evict) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
   end

   always_comb begin
      rsp_next = '0;
      unique case (key_ff.opcode)
         OP_ADD: rsp_next.accepted = !dup;
         OP_FORWARD: begin
            if (occ_zero) begin
               rsp_next.queue_empty = 1'b1;
            end else begin
               rsp_next.out_source      = cell_entry[0].source;
               rsp_next.out_destination = cell_entry[0].destination;
               rsp_next.out_timestamp   = cell_entry[0].timestamp;
            end
         end
         OP_COUNT: rsp_next.match_count = acc_ff;
         default: rsp_next = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         limit_ff     <= MEM_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      scan_ff     <= scan_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cell chain: cell 0 holds the oldest packet, a pop shifts toward it
   assign cell_ctrl.shift      = finish_go &&
                                 ((is_fwd && !occ_zero) || (do_store && evict));
   assign cell_ctrl.count_mode = is_count;
   assign cell_ctrl.key        = '{source: key_ff.source,
                                   destination: key_ff.destination,
                                   timestamp: key_ff.timestamp};
   assign cell_ctrl.start_time = key_ff.start_time;
   assign cell_ctrl.end_time   = key_ff.end_time;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      dpf_entry_type nxt_entry;
      logic          nxt_valid;

      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign nxt_entry = '0;
         assign nxt_valid = 1'b0;
      end else begin : g_mid
         assign nxt_entry = cell_entry[g+1];
         assign nxt_valid = cell_valid[g+1];
      end

      assign load_vec[g] = wr_en && (wr_idx == IDX_W'(g));

      dpf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .load_here  (load_vec[g]),
         .next_entry (nxt_entry),
         .next_valid (nxt_valid),
         .entry      (cell_entry[g]),
         .valid      (cell_valid[g]),
         .match      (cell_match[g])
      );
   end

endmodule

// ===== rtl/dpf_checker.sv =====
`include "dedup_packet_fifo_with_range_count_top_macros.svh"

module dpf_checker import dpf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input dpf_rsp_type rsp_data
);

   `DPF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   `DPF_ASSERT(a_busy_after_take, clock, reset, req_valid && !req_stall |=> req_stall, "request taken while busy")

   `DPF_ASSERT(a_add_only, clock, reset, rsp_valid && rsp_data.accepted |-> !rsp_data.queue_empty && rsp_data.match_count == 7'd0 && rsp_data.out_timestamp == 32'd0, "add response carries other fields")

   `DPF_ASSERT(a_empty_zero, clock, reset, rsp_valid && rsp_data.queue_empty |-> rsp_data.out_source == 16'd0 && rsp_data.out_destination == 16'd0 && rsp_data.out_timestamp == 32'd0, "empty forward carries packet data")

   `DPF_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind dedup_packet_fifo_with_range_count_top dpf_checker u_dpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/dedup_packet_fifo_with_range_count_top_test.sv =====
module dedup_packet_fifo_with_range_count_top_test;
   import dpf_pkg::*;

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_NONE = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_BURSTY = 2;
   localparam int WATCHDOG_LIMIT = 1000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   dpf_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   dpf_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_data;

   // shadow of the packet queue and the limit register
   dpf_entry_type queued_packets[$];
   logic [6:0]    limit_reg = MEM_LIMIT_RESET;
   dpf_rsp_type   expected_responses[$];

   logic [15:0] src_pool[8];
   logic [15:0] dst_pool[4];
   logic [31:0] ts_pool[16];

   int error_count = 0;
   int idle_cycles = 0;
   int checked_count = 0;
   int stall_mode = STALL_NONE;
   int stall_phase = 0;
   int burst_left = 0;
   int gap_max = 0;
   int n_add = 0, n_dup = 0, n_fwd = 0, n_empty = 0, n_count = 0, n_unused = 0;
   int n_evict = 0, n_cfg = 0;

   dedup_packet_fifo_with_range_count_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #10 clock = 1'b1;
      #10;
   end

   function automatic dpf_rsp_type predict_response(input dpf_req_type r);
      dpf_rsp_type   rsp;
      dpf_entry_type entry;
      bit            dup;
      int            cap;
      int            hits;
      rsp = '0;
      case (r.opcode)
         OP_ADD: begin
            n_add++;
            entry.source = r.source;
            entry.destination = r.destination;
            entry.timestamp = r.timestamp;
            dup = 1'b0;
            foreach (queued_packets[i])
               if (queued_packets[i] == entry) dup = 1'b1;
            if (dup) begin
               n_dup++;
            end else begin
               cap = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
               // only one oldest packet goes per add, even if the limit was lowered
               if (queued_packets.size() >= cap && queued_packets.size() > 0) begin
                  void'(queued_packets.pop_front());
                  n_evict++;
               end
               if (queued_packets.size() >= DEPTH) begin
                  void'(queued_packets.pop_front());
                  n_evict++;
               end
               queued_packets.push_back(entry);
               rsp.accepted = 1'b1;
            end
         end
         OP_FORWARD: begin
            n_fwd++;
            if (queued_packets.size() == 0) begin
               rsp.queue_empty = 1'b1;
               n_empty++;
            end else begin
               entry = queued_packets.pop_front();
               rsp.out_source = entry.source;
               rsp.out_destination = entry.destination;
               rsp.out_timestamp = entry.timestamp;
            end
         end
         OP_COUNT: begin
            n_count++;
            hits = 0;
            foreach (queued_packets[i])
               if (queued_packets[i].destination == r.destination &&
                   queued_packets[i].timestamp >= r.start_time &&
                   queued_packets[i].timestamp <= r.end_time) hits++;
            rsp.match_count = (hits > 127) ? 7'd127 : 7'(hits);
         end
         default: begin
            n_unused++;
         end
      endcase
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [127:0] got,
                                  input logic [127:0] want);
      error_count++;
      $display("mismatch at response %0d: %s got %0h expected %0h",
               checked_count, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(what, 128'(got), 128'(want));
   endtask

   always @(posedge clock) begin : txn_monitor
      dpf_rsp_type want;
      bit          activity;
      if (!reset) begin
         activity = 1'b0;
         if (req_valid && !req_stall) begin
            expected_responses.push_back(predict_response(req_data));
            activity = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            limit_reg = csr_data;
            n_cfg++;
            activity = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            activity = 1'b1;
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 128'(rsp_data), '0);
            end else begin
               want = expected_responses.pop_front();
               check_field("accepted", 64'(rsp_data.accepted), 64'(want.accepted));
               check_field("queue_empty", 64'(rsp_data.queue_empty),
                           64'(want.queue_empty));
               check_field("out_source", 64'(rsp_data.out_source), 64'(want.out_source));
               check_field("out_destination", 64'(rsp_data.out_destination),
                           64'(want.out_destination));
               check_field("out_timestamp", 64'(rsp_data.out_timestamp),
                           64'(want.out_timestamp));
               check_field("match_count", 64'(rsp_data.match_count),
                           64'(want.match_count));
            end
            checked_count++;
         end
         idle_cycles = activity ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("dedup_packet_fifo_with_range_count_top_test: errors");
      $finish;
   end

   // result-side backpressure, independent of the sender
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_RANDOM: rsp_stall <= ($urandom_range(99) < 35);
         STALL_BURSTY: rsp_stall <= ((stall_phase % 11) < 4);
         default:      rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_request(input dpf_req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if (gap_max > 0) hold_off($urandom_range(gap_max, 0));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_memory_limit(input logic [6:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic dpf_req_type make_request(input logic [1:0] op, input logic [15:0] src,
                                                input logic [15:0] dst, input logic [31:0] ts,
                                                input logic [31:0] lo, input logic [31:0] hi);
      dpf_req_type r;
      r.opcode = op;
      r.source = src;
      r.destination = dst;
      r.timestamp = ts;
      r.start_time = lo;
      r.end_time = hi;
      return r;
   endfunction

   task automatic send_paced(input dpf_req_type item);
      send_request(item);
      pace_sender();
   endtask

   task automatic refill_pools();
      foreach (src_pool[i]) src_pool[i] = 16'($urandom);
      foreach (dst_pool[i]) dst_pool[i] = 16'($urandom);
      foreach (ts_pool[i]) ts_pool[i] = $urandom;
      src_pool[0] = 16'h0000;
      src_pool[1] = 16'hFFFF;
      dst_pool[0] = 16'hFFFF;
      ts_pool[0] = 32'h0000_0000;
      ts_pool[1] = 32'hFFFF_FFFF;
   endtask

   function automatic dpf_req_type random_request(input int add_weight, input int fwd_weight);
      dpf_req_type   r;
      dpf_entry_type held;
      int            k;
      int            pick;
      logic [31:0]   delta;
      r.source = ($urandom_range(3) == 0) ? 16'($urandom) : src_pool[$urandom_range(7)];
      r.destination = ($urandom_range(3) == 0) ? 16'($urandom) : dst_pool[$urandom_range(3)];
      r.timestamp = ($urandom_range(3) == 0) ? $urandom : ts_pool[$urandom_range(15)];
      r.start_time = $urandom;
      r.end_time = $urandom;
      k = $urandom_range(99);
      if (k < add_weight) begin
         r.opcode = OP_ADD;
         // re-offer a packet that is still queued
         if (queued_packets.size() > 0 && $urandom_range(4) == 0) begin
            held = queued_packets[$urandom_range(queued_packets.size() - 1)];
            r.source = held.source;
            r.destination = held.destination;
            r.timestamp = held.timestamp;
         end
      end else if (k < add_weight + fwd_weight) begin
         r.opcode = OP_FORWARD;
      end else if (k < 97) begin
         r.opcode = OP_COUNT;
         pick = $urandom_range(3);
         if (queued_packets.size() > 0 && pick != 3) begin
            held = queued_packets[$urandom_range(queued_packets.size() - 1)];
            r.destination = held.destination;
            case (pick)
               0: begin
                  r.start_time = 32'h0000_0000;
                  r.end_time = 32'hFFFF_FFFF;
               end
               1: begin
                  delta = $urandom_range(5000);
                  r.start_time = (held.timestamp > delta) ? held.timestamp - delta : 32'd0;
                  r.end_time = (held.timestamp > 32'hFFFF_FFFF - delta) ? 32'hFFFF_FFFF
                                                                        : held.timestamp + delta;
               end
               default: begin
                  r.start_time = held.timestamp;
                  r.end_time = held.timestamp;
               end
            endcase
         end
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic test_directed_basics();
      gap_max = 2;
      stall_mode = STALL_RANDOM;
      send_paced(make_request(OP_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
      send_paced(make_request(OP_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
      send_paced(make_request(OP_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
      send_paced(make_request(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_paced(make_request(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_paced(make_request(OP_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF));
      // reversed range matches nothing
      send_paced(make_request(OP_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
      send_paced(make_request(OP_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
      send_paced(make_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
      repeat (3) send_paced(make_request(OP_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
   endtask

   task automatic test_limit_extremes();
      // zero acts as one: second add drops the first
      write_memory_limit(7'd0);
      send_paced(make_request(OP_ADD, 16'd1, 16'd2, 32'd3, 32'd0, 32'd0));
      send_paced(make_request(OP_ADD, 16'd4, 16'd5, 32'd6, 32'd0, 32'd0));
      repeat (2) send_paced(make_request(OP_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
      write_memory_limit(7'd1);
      send_paced(make_request(OP_ADD, 16'd7, 16'd8, 32'd9, 32'd0, 32'd0));
      send_paced(make_request(OP_ADD, 16'd7, 16'd8, 32'd9, 32'd0, 32'd0));
      send_paced(make_request(OP_COUNT, 16'd0, 16'd8, 32'd0, 32'd0, 32'hFFFF_FFFF));
      send_paced(make_request(OP_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
      // above depth saturates
      write_memory_limit(7'd127);
      send_paced(make_request(OP_ADD, 16'd1, 16'd1, 32'd1, 32'd0, 32'd0));
      send_paced(make_request(OP_ADD, 16'd2, 16'd2, 32'd2, 32'd0, 32'd0));
      send_paced(make_request(OP_COUNT, 16'd0, 16'd1, 32'd0, 32'd1, 32'd1));
      repeat (2) send_paced(make_request(OP_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
   endtask

   task automatic test_limit_lowered_while_full();
      gap_max = 3;
      stall_mode = STALL_BURSTY;
      write_memory_limit(7'd64);
      for (int i = 0; i < DEPTH; i++)
         send_paced(make_request(OP_ADD, 16'(i), 16'(i % 4), 32'(i * 1000), 32'd0, 32'd0));
      // one more at full depth evicts the oldest
      send_paced(make_request(OP_ADD, 16'hABCD, 16'd1, 32'd77, 32'd0, 32'd0));
      write_memory_limit(7'd4);
      send_paced(make_request(OP_ADD, 16'h1111, 16'd2, 32'd5, 32'd0, 32'd0));
      send_paced(make_request(OP_ADD, 16'h2222, 16'd3, 32'd6, 32'd0, 32'd0));
      send_paced(make_request(OP_ADD, 16'd10, 16'd2, 32'd10000, 32'd0, 32'd0));
      send_paced(make_request(OP_COUNT, 16'd0, 16'd1, 32'd0, 32'd0, 32'hFFFF_FFFF));
      send_paced(make_request(OP_COUNT, 16'd0, 16'd2, 32'd0, 32'd20000, 32'd40000));
      repeat (DEPTH + 2)
         send_paced(make_request(OP_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
      for (int i = 0; i < 6; i++)
         send_paced(make_request(OP_ADD, 16'(i + 500), 16'd9, 32'(i), 32'd0, 32'd0));
      send_paced(make_request(OP_COUNT, 16'd0, 16'd9, 32'd0, 32'd0, 32'hFFFF_FFFF));
      repeat (5) send_paced(make_request(OP_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
   endtask

   task automatic test_random_traffic(input logic [6:0] limit, input int items,
                                      input int add_weight, input int fwd_weight,
                                      input int stall_kind, input int gap_limit);
      int pause_at;
      write_memory_limit(limit);
      stall_mode = stall_kind;
      gap_max = gap_limit;
      refill_pools();
      pause_at = $urandom_range(items - 1);
      for (int i = 0; i < items; i++) begin
         if (i == pause_at) wait_drained();
         send_paced(random_request(add_weight, fwd_weight));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_limit_extremes();
      test_limit_lowered_while_full();
      test_random_traffic(7'd64, 400, 60, 20, STALL_RANDOM, 6);
      test_random_traffic(7'd1, 150, 50, 25, STALL_BURSTY, 4);
      test_random_traffic(7'd0, 150, 50, 25, STALL_RANDOM, 3);
      test_random_traffic(7'd127, 300, 60, 20, STALL_NONE, 0);
      test_random_traffic(7'd8, 200, 45, 30, STALL_BURSTY, 8);
      test_random_traffic(7'($urandom_range(63, 1)), 200, 50, 25, STALL_RANDOM, 5);
      test_random_traffic(7'($urandom_range(127)), 100, 40, 35, STALL_RANDOM, 10);

      wait_drained();
      repeat (20) @(posedge clock);
      if (expected_responses.size() != 0)
         report_mismatch("responses never arrived", 128'(expected_responses.size()),
                         128'(0));
      $display("covered %0d adds (%0d duplicates, %0d evictions), %0d forwards (%0d empty),",
               n_add, n_dup, n_evict, n_fwd, n_empty);
      $display("%0d counts, %0d unused opcodes, %0d limit writes, %0d responses checked",
               n_count, n_unused, n_cfg, checked_count);
      if (error_count == 0) begin
         $display("dedup_packet_fifo_with_range_count_top_test: clean");
      end else begin
         $display("dedup_packet_fifo_with_range_count_top_test: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dpf_pkg.sv
rtl/dpf_cell.sv
rtl/dedup_packet_fifo_with_range_count_top.sv
rtl/dpf_checker.sv
verif/dedup_packet_fifo_with_range_count_top_test.sv
